>>> sv/abal_pkg.sv
package abal_pkg;

    localparam int BASE_W = 40;
    localparam int CNT_W  = 25;
    localparam int USED_W = 25;
    localparam int ADDR_W = 41;
    localparam int DIV_W  = 26;
    localparam int PROD_W = 2 * CNT_W;
    localparam int STAT_W = 2;

    // The remainder unit walks every bit of the widest dividend.
    localparam int REM_ITERS = ADDR_W;
    localparam int REM_CNT_W = $clog2(REM_ITERS + 1);
    localparam int MUL_CNT_W = $clog2(CNT_W + 1);

    localparam int HEAP_BYTES_DEF = 16777216;
    localparam int LINE_BYTES_DEF = 64;

    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_PAD  = 2'd1;
    localparam status_t ST_NO_ROOM = 2'd2;

endpackage

>>> sv/abal_rem.sv
module abal_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [abal_pkg::ADDR_W-1:0]   dividend,
    input  logic [abal_pkg::DIV_W-1:0]    divisor,
    output logic                          done,
    output logic [abal_pkg::DIV_W-1:0]    rem
);

    logic [abal_pkg::REM_CNT_W-1:0] cnt_reg;
    logic [abal_pkg::REM_CNT_W-1:0] cnt_next;
    logic                           done_reg;
    logic                           done_next;
    logic [abal_pkg::ADDR_W-1:0]    dend_reg;
    logic [abal_pkg::DIV_W-1:0]     dsor_reg;
    logic [abal_pkg::DIV_W-1:0]     rem_reg;
    logic [abal_pkg::DIV_W:0]       trial;
    logic [abal_pkg::DIV_W:0]       diff;
    logic                           fits;

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    always_comb
    begin
        trial = {rem_reg, dend_reg[abal_pkg::ADDR_W-1]};
        diff  = trial - {1'b0, dsor_reg};
        fits  = (trial >= {1'b0, dsor_reg});
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = abal_pkg::REM_CNT_W'(abal_pkg::REM_ITERS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == abal_pkg::REM_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dend_reg <= dividend;
            dsor_reg <= divisor;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dend_reg <= {dend_reg[abal_pkg::ADDR_W-2:0], 1'b0};
            rem_reg  <= fits ? diff[abal_pkg::DIV_W-1:0] : trial[abal_pkg::DIV_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/abal_mul.sv
module abal_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [abal_pkg::CNT_W-1:0]    mcand,
    input  logic [abal_pkg::CNT_W-1:0]    mplier,
    output logic                          busy,
    output logic [abal_pkg::PROD_W-1:0]   product
);

    logic [abal_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [abal_pkg::MUL_CNT_W-1:0] cnt_next;
    logic [abal_pkg::CNT_W-1:0]     mcand_reg;
    logic [abal_pkg::PROD_W-1:0]    prod_reg;
    logic [abal_pkg::CNT_W:0]       sum;

    // Shift-add: the multiplier sits in the low half and leaves one bit a cycle.
    always_comb
    begin
        sum = {1'b0, prod_reg[abal_pkg::PROD_W-1:abal_pkg::CNT_W]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = abal_pkg::MUL_CNT_W'(abal_pkg::CNT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            prod_reg  <= {{abal_pkg::CNT_W{1'b0}}, mplier};
        end
        else if (cnt_reg != '0)
        begin
            prod_reg <= {sum, prod_reg[abal_pkg::CNT_W-1:1]};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = prod_reg;

endmodule

>>> sv/aligned_bump_allocator.sv
// Bump allocator with alignment. Each word asks for elem_count elements of
// elem_size bytes; the block pads heap_base plus the bytes used so far up to a
// multiple of elem_size + LINE_BYTES - (elem_size mod LINE_BYTES), reserves the
// object there and returns its address with status 0. Status 1 means the padding
// does not fit in the heap, status 2 that the object does not; on an error the
// address is 0 and the used count stays as it was. One word is in flight at a
// time: two passes through the one-bit-per-cycle remainder unit (size mod line,
// then address mod divisor), each made of 41 bit steps, with the serial
// multiplier running beside the first pass, then the checks. The next word can
// be accepted the cycle after the result is registered. The user must write
// heap_base only while no word is in flight; the block itself does not enforce
// it.
module aligned_bump_allocator #(
    parameter int HEAP_BYTES = abal_pkg::HEAP_BYTES_DEF,
    parameter int LINE_BYTES = abal_pkg::LINE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [abal_pkg::BASE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [abal_pkg::CNT_W-1:0]    elem_count,
    input  logic [abal_pkg::CNT_W-1:0]    elem_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [abal_pkg::ADDR_W-1:0]   address,
    output logic [abal_pkg::STAT_W-1:0]   status
);

    localparam int U2_W = abal_pkg::DIV_W + 1;

    localparam logic [abal_pkg::USED_W-1:0] HEAP_V = abal_pkg::USED_W'(HEAP_BYTES);
    localparam logic [abal_pkg::DIV_W-1:0]  LINE_V = abal_pkg::DIV_W'(LINE_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [abal_pkg::BASE_W-1:0]     heap_base_reg;
    logic [abal_pkg::USED_W-1:0]     used_reg;
    logic [abal_pkg::USED_W-1:0]     used_next;
    logic                            out_valid_reg;
    logic [abal_pkg::ADDR_W-1:0]     address_reg;
    abal_pkg::status_t               status_reg;
    abal_pkg::status_t               status_next;

    logic [abal_pkg::CNT_W-1:0]      size_reg;
    logic [abal_pkg::DIV_W-1:0]      div_reg;
    logic [abal_pkg::ADDR_W-1:0]     cur_reg;
    logic [abal_pkg::DIV_W-1:0]      pad_reg;
    logic [abal_pkg::USED_W-1:0]     room_reg;
    logic [U2_W-1:0]                 used2_reg;
    logic                            err1_reg;

    logic                            accept;
    logic                            rem_start;
    logic [abal_pkg::ADDR_W-1:0]     rem_dividend;
    logic [abal_pkg::DIV_W-1:0]      rem_divisor;
    logic                            rem_done;
    logic [abal_pkg::DIV_W-1:0]      rem_val;
    logic                            mul_busy;
    logic [abal_pkg::PROD_W-1:0]     product;

    logic [abal_pkg::DIV_W-1:0]      div_calc;
    logic [abal_pkg::ADDR_W-1:0]     cur_calc;
    logic [abal_pkg::DIV_W-1:0]      pad_calc;
    logic [abal_pkg::USED_W-1:0]     room_calc;
    logic [U2_W-1:0]                 room2;
    logic                            err2;
    logic                            out_free;
    logic                            fin_write;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign fin_write = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        div_calc  = abal_pkg::DIV_W'(size_reg) + LINE_V - rem_val;
        cur_calc  = {1'b0, heap_base_reg} + abal_pkg::ADDR_W'(used_reg);
        pad_calc  = (rem_val == '0) ? '0 : div_reg - rem_val;
        room_calc = (used_reg > HEAP_V) ? '0 : HEAP_V - used_reg;
        room2     = U2_W'(HEAP_V) - used2_reg;
        err2      = (product > abal_pkg::PROD_W'(room2));
    end

    // The remainder unit first gives size mod line, then the address mod divisor.
    always_comb
    begin
        rem_start    = 1'b0;
        rem_dividend = abal_pkg::ADDR_W'(elem_size);
        rem_divisor  = LINE_V;
        if (accept)
        begin
            rem_start = 1'b1;
        end
        else if (state_reg == S_MOD && rem_done)
        begin
            rem_start    = 1'b1;
            rem_dividend = cur_calc;
            rem_divisor  = div_calc;
        end
    end

    abal_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .done     (rem_done),
        .rem      (rem_val)
    );

    abal_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .mcand   (elem_size),
        .mplier  (elem_count),
        .busy    (mul_busy),
        .product (product)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (rem_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (err1_reg)
        begin
            status_next = abal_pkg::ST_NO_PAD;
        end
        else if (err2)
        begin
            status_next = abal_pkg::ST_NO_ROOM;
        end
        else
        begin
            status_next = abal_pkg::ST_OK;
            used_next   = used2_reg[abal_pkg::USED_W-1:0]
                        + product[abal_pkg::USED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_base_reg <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                heap_base_reg <= cfg_data;
            end
            if (fin_write)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg <= elem_size;
        end
        if (state_reg == S_MOD && rem_done)
        begin
            div_reg <= div_calc;
            cur_reg <= cur_calc;
        end
        if (state_reg == S_DIV && rem_done)
        begin
            pad_reg  <= pad_calc;
            room_reg <= room_calc;
        end
        if (state_reg == S_CHK)
        begin
            err1_reg  <= (pad_reg > abal_pkg::DIV_W'(room_reg));
            used2_reg <= U2_W'(used_reg) + U2_W'(pad_reg);
        end
        if (fin_write)
        begin
            status_reg  <= status_next;
            address_reg <= (status_next == abal_pkg::ST_OK)
                         ? cur_reg + abal_pkg::ADDR_W'(pad_reg) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign status    = status_reg;

    a_rem_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (state_reg == S_MOD || state_reg == S_DIV))
        else $error("remainder unit finished outside a division pass");

    a_mul_before_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && rem_done) |-> !mul_busy)
        else $error("product not ready when the checks begin");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MOD))
        else $error("accepted word did not start the first pass");

    a_used_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= HEAP_V)
        else $error("used byte count ran past the heap");

endmodule

>>> tb/tb_aligned_bump_allocator.sv
module tb_aligned_bump_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_B       = abal_pkg::HEAP_BYTES_DEF;
    localparam int LINE_B       = abal_pkg::LINE_BYTES_DEF;
    localparam int FIELD_TOP    = 1 << 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [abal_pkg::BASE_W-1:0] BASE_TOP = '1;
    localparam longint unsigned USED_MASK = (64'd1 << abal_pkg::USED_W) - 64'd1;

    typedef struct packed {
        logic [abal_pkg::CNT_W-1:0] count;
        logic [abal_pkg::CNT_W-1:0] size;
    } alloc_req_t;

    typedef struct packed {
        logic [abal_pkg::ADDR_W-1:0] addr;
        abal_pkg::status_t           status;
    } alloc_res_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [abal_pkg::BASE_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [abal_pkg::CNT_W-1:0]  elem_count = '0;
    logic [abal_pkg::CNT_W-1:0]  elem_size = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [abal_pkg::ADDR_W-1:0] address;
    logic [abal_pkg::STAT_W-1:0] status;

    alloc_req_t                  req_queue[$];
    alloc_res_t                  grant_queue[$];
    logic [abal_pkg::BASE_W-1:0] base_m = '0;
    longint unsigned             used_m = 0;
    int                          errors = 0;
    int                          tx_idle_pct = 0;
    int                          rx_idle_pct = 0;
    int                          hold_seq = 0;
    int                          hold_seen = 0;
    int                          hold_left = 0;
    int                          stall_cnt = 0;

    aligned_bump_allocator #(
        .HEAP_BYTES(HEAP_B),
        .LINE_BYTES(LINE_B)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elem_count(elem_count),
        .elem_size (elem_size),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .address   (address),
        .status    (status)
    );

    always #2 clk = ~clk;

    // Works out the grant for one request and, on success, advances the used byte count.
    function automatic alloc_res_t predict_grant(input alloc_req_t r);
        longint unsigned full;
        longint unsigned cur;
        longint unsigned div;
        longint unsigned rem;
        longint unsigned pad;
        longint unsigned room;
        alloc_res_t      res;
        full = 64'(r.count) * 64'(r.size);
        cur  = 64'(base_m) + used_m;
        div  = 64'(r.size) + LINE_B - (64'(r.size) % LINE_B);
        rem  = cur % div;
        pad  = (rem == 0) ? 0 : div - rem;
        room = (used_m > HEAP_B) ? 0 : HEAP_B - used_m;
        res.addr = '0;
        if (pad > room)
        begin
            res.status = abal_pkg::ST_NO_PAD;
        end
        else if (full > HEAP_B - (used_m + pad))
        begin
            res.status = abal_pkg::ST_NO_ROOM;
        end
        else
        begin
            res.status = abal_pkg::ST_OK;
            res.addr   = abal_pkg::ADDR_W'(cur + pad);
            used_m     = (used_m + pad + full) & USED_MASK;
        end
        return res;
    endfunction

    // Sender: takes requests from the pending queue, predicts on acceptance.
    always @(posedge clk)
    begin
        alloc_req_t taken;
        if (in_valid && in_ready)
        begin
            taken = '{count: elem_count, size: elem_size};
            grant_queue.push_back(predict_grant(taken));
        end
        if (!in_valid || in_ready)
        begin
            if (rst_n && req_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                taken = req_queue.pop_front();
                in_valid   <= 1'b1;
                elem_count <= taken.count;
                elem_size  <= taken.size;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result word against the oldest expected grant.
    always @(posedge clk)
    begin
        alloc_res_t want;
        if (out_valid && out_ready)
        begin
            if (grant_queue.size() == 0)
            begin
                $display("%t: unexpected result, address %h status %0d", $time, address, status);
                errors++;
            end
            else
            begin
                want = grant_queue.pop_front();
                if (address !== want.addr)
                begin
                    $display("%t: address mismatch, expected %h actual %h",
                             $time, want.addr, address);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%t: status mismatch, expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
            end
        end
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cnt <= 0;
        end
        else if (stall_cnt == STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_req(input longint unsigned cnt, input longint unsigned sz);
        alloc_req_t r;
        r.count = abal_pkg::CNT_W'(cnt);
        r.size  = abal_pkg::CNT_W'(sz);
        req_queue.push_back(r);
    endtask

    // Returns at a falling edge once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        @(negedge clk);
        while (req_queue.size() != 0 || in_valid || grant_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_base(input logic [abal_pkg::BASE_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        base_m = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small requests so the heap lasts; wide ones toggle the upper bits
    // and, apart from zero-size ones, are too big to ever fit.
    task automatic random_reqs(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 74)
                push_req($urandom_range(0, 15), $urandom_range(0, 255));
            else if (pick < 87)
                push_req($urandom_range(0, FIELD_TOP), 0);
            else
                push_req($urandom_range(1 << 20, FIELD_TOP), $urandom_range(16, FIELD_TOP));
        end
    endtask

    // Pads to a line boundary with one-byte elements and asks for exactly the
    // room left, after one request that is a byte too large.
    task automatic fill_heap();
        longint unsigned cur;
        longint unsigned pad;
        longint unsigned room;
        cur  = 64'(base_m) + used_m;
        pad  = (LINE_B - cur % LINE_B) % LINE_B;
        room = HEAP_B - used_m;
        if (pad <= room)
        begin
            push_req(room - pad + 1, 1);
            push_req(room - pad, 1);
        end
        push_req(1, 1);
        push_req(0, 1);
        push_req(0, 0);
        push_req(FIELD_TOP, 0);
    endtask

    initial
    begin
        tx_idle_pct = 14;
        rx_idle_pct = 53;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_base('0);

        // The heap starts empty at address zero, so the huge zero-count request
        // needs no padding; later huge sizes cannot be padded.
        push_req(0, FIELD_TOP);
        push_req(1, 1);
        push_req(0, 0);
        push_req(7, 0);
        push_req(0, 100);
        push_req(3, 64);
        push_req(2, 63);
        push_req(5, 65);
        push_req(0, FIELD_TOP);
        push_req(1, FIELD_TOP);
        push_req(FIELD_TOP, 1);
        push_req(FIELD_TOP, 0);
        push_req(FIELD_TOP, FIELD_TOP);
        // Padding uses up exactly the room left, then the object does not fit.
        push_req(FIELD_TOP - 1, FIELD_TOP - 1);
        push_req(1, 4096);
        push_req(12, 255);
        push_req(1, 1);
        wait_idle();

        write_base(BASE_TOP);
        random_reqs(430);
        @(posedge clk);
        hold_seq <= hold_seq + 1;
        wait_idle();

        tx_idle_pct = 53;
        rx_idle_pct = 14;
        write_base({8'($urandom_range(0, 255)), $urandom()});
        random_reqs(430);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_base({8'($urandom_range(0, 255)), $urandom()});
        random_reqs(420);
        wait_idle();
        fill_heap();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && grant_queue.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/abal_pkg.sv
sv/abal_rem.sv
sv/abal_mul.sv
sv/aligned_bump_allocator.sv
tb/tb_aligned_bump_allocator.sv
